>>> rtl/core/ppa_pkg.sv
// Shared types and constants for the physical page allocator.
// Holds the request/response payload structs, status codes and the
// command/status bundles between the controller and the datapath.
`default_nettype none

package ppa_pkg;

	// Default sizing of the usage map
	localparam int MAX_PAGES  = 4096;
	localparam int PAGE_SHIFT = 12;

	// Field widths
	localparam int PAGE_W  = 13;
	localparam int ADDR_W  = 32;
	localparam int GADDR_W = 24;
	localparam int IDX_W   = ADDR_W - PAGE_SHIFT;
	localparam int CFG_IDX_W = 2;

	// Configuration reset values
	localparam logic [PAGE_W-1:0] FIRST_PAGE_RST = 13'd256;
	localparam logic [PAGE_W-1:0] PAGE_COUNT_RST = 13'd4096;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FIRST_PAGE = 2'd0,
		REG_PAGE_COUNT = 2'd1
	} reg_idx_t;

	typedef enum logic {
		OP_ALLOC   = 1'b0,
		OP_RELEASE = 1'b1
	} op_t;

	typedef enum logic [2:0] {
		ST_OK         = 3'd0,
		ST_OOM        = 3'd1,
		ST_MISALIGNED = 3'd2,
		ST_RANGE      = 3'd3,
		ST_NOT_USED   = 3'd4
	} status_t;

	typedef struct packed {
		logic              operation;
		logic [ADDR_W-1:0] page_address;
	} req_t;

	typedef struct packed {
		logic [GADDR_W-1:0] granted_address;
		status_t            status;
		logic [PAGE_W-1:0]  free_count;
	} rsp_t;

	// Controller to datapath
	typedef struct packed {
		logic take;
		logic clr_wr;
		logic rc_start;
		logic cnt_init;
		logic cnt_next;
		logic rd_en;
		logic rd_rel;
		logic rc_acc;
		logic al_chk;
		logic rel_chk;
		logic rel_reject;
		logic oom;
		logic rsp_load;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic clr_last;
		logic dirty;
		logic empty;
		logic is_release;
		logic rel_bad;
		logic hit;
		logic last;
		logic rsp_free;
	} sts_t;

endpackage

`default_nettype wire

>>> rtl/core/ppa_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package dependency.
`default_nettype none

module ppa_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  wire logic                                  clk,
	input  wire logic                                  wr_en,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]                      wr_data,
	input  wire logic                                  rd_en,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic      [WIDTH-1:0]                      rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/ppa_ctrl.sv
// Sequencing state machine of the page allocator.
// Uses ppa_pkg for the command and status bundles.
`default_nettype none

module ppa_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_ready,
	output ppa_pkg::cmd_t      cmd,
	input  wire ppa_pkg::sts_t sts
);

	typedef enum logic [9:0] {
		S_CLEAR   = 10'b00_0000_0001,
		S_IDLE    = 10'b00_0000_0010,
		S_PREP    = 10'b00_0000_0100,
		S_RC_RD   = 10'b00_0000_1000,
		S_RC_CHK  = 10'b00_0001_0000,
		S_OP      = 10'b00_0010_0000,
		S_AL_RD   = 10'b00_0100_0000,
		S_AL_CHK  = 10'b00_1000_0000,
		S_REL_CHK = 10'b01_0000_0000,
		S_RSP     = 10'b10_0000_0000
	} state_t;

	state_t state_q;
	state_t state_d;

	assign req_ready = (state_q == S_IDLE);

	// Next state and datapath commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_CLEAR: begin
				cmd.clr_wr = 1'b1;
				if (sts.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (req_valid) begin
					cmd.take = 1'b1;
					state_d  = S_PREP;
				end
			end
			S_PREP: begin
				// Recount the in-range usage after a register change
				if (sts.dirty) begin
					cmd.rc_start = 1'b1;
					cmd.cnt_init = 1'b1;
					state_d      = sts.empty ? S_OP : S_RC_RD;
				end else begin
					state_d = S_OP;
				end
			end
			S_RC_RD: begin
				cmd.rd_en = 1'b1;
				state_d   = S_RC_CHK;
			end
			S_RC_CHK: begin
				cmd.rc_acc = 1'b1;
				if (sts.last) begin
					state_d = S_OP;
				end else begin
					cmd.cnt_next = 1'b1;
					state_d      = S_RC_RD;
				end
			end
			S_OP: begin
				if (sts.is_release) begin
					if (sts.rel_bad) begin
						cmd.rel_reject = 1'b1;
						state_d        = S_RSP;
					end else begin
						cmd.rd_en  = 1'b1;
						cmd.rd_rel = 1'b1;
						state_d    = S_REL_CHK;
					end
				end else if (sts.empty) begin
					cmd.oom = 1'b1;
					state_d = S_RSP;
				end else begin
					cmd.cnt_init = 1'b1;
					state_d      = S_AL_RD;
				end
			end
			S_AL_RD: begin
				cmd.rd_en = 1'b1;
				state_d   = S_AL_CHK;
			end
			S_AL_CHK: begin
				cmd.al_chk = 1'b1;
				if (sts.hit || sts.last) begin
					state_d = S_RSP;
				end else begin
					cmd.cnt_next = 1'b1;
					state_d      = S_AL_RD;
				end
			end
			S_REL_CHK: begin
				cmd.rel_chk = 1'b1;
				state_d     = S_RSP;
			end
			S_RSP: begin
				// Hold until the output register can take the result
				if (sts.rsp_free) begin
					cmd.rsp_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/ppa_datapath.sv
// Datapath of the page allocator: usage-map RAM, word scanner,
// configuration registers, usage counter and response register.
// Uses ppa_pkg and instantiates ppa_ram.
`default_nettype none

module ppa_datapath #(
	parameter int MAX_PAGES = ppa_pkg::MAX_PAGES
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire ppa_pkg::cmd_t                      cmd,
	output ppa_pkg::sts_t                           sts,
	input  wire ppa_pkg::req_t                      req,
	input  wire logic                               cfg_valid,
	input  wire logic [ppa_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [ppa_pkg::PAGE_W-1:0]         cfg_data,
	output logic                                    rsp_valid,
	input  wire logic                               rsp_ready,
	output ppa_pkg::rsp_t                           rsp
);

	localparam int WORD_W = (MAX_PAGES >= 32) ? 32 : 16;
	localparam int WS     = $clog2(WORD_W);
	localparam int DEPTH  = (MAX_PAGES + WORD_W - 1) / WORD_W;
	localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int PW     = ppa_pkg::PAGE_W;
	localparam int IW     = PW - WS;
	localparam logic [PW-1:0] MAXP_CLIP =
		(MAX_PAGES >= (1 << PW)) ? {PW{1'b1}} : PW'(MAX_PAGES);
	localparam logic [AW-1:0] CLR_END = AW'(DEPTH - 1);

	logic [PW-1:0]     first_page_q;
	logic [PW-1:0]     page_count_q;
	logic              dirty_q;
	logic [PW-1:0]     used_q;
	logic [AW-1:0]     clr_q;
	logic [IW-1:0]     wrd_q;
	logic              op_q;
	logic [ppa_pkg::ADDR_W-1:0]  addr_q;
	logic [ppa_pkg::GADDR_W-1:0] gaddr_q;
	ppa_pkg::status_t  stat_q;
	ppa_pkg::rsp_t     rsp_q;
	logic              rsp_valid_q;

	logic [PW-1:0]     lim;
	logic [PW-1:0]     lim_m1;
	logic              empty;
	logic [PW-1:0]     span;
	logic [IW-1:0]     fw;
	logic [IW-1:0]     lw;
	logic              last;
	logic [WORD_W-1:0] lo_mask;
	logic [WORD_W-1:0] hi_mask;
	logic [WORD_W-1:0] mask;
	logic [WORD_W-1:0] rdata;
	logic [WORD_W-1:0] free_bits;
	logic              hit;
	logic [WS-1:0]     bit_idx;
	logic [PW-1:0]     grant_page;
	logic [WORD_W-1:0] al_onehot;
	logic [ppa_pkg::IDX_W-1:0] rel_idx;
	logic              misaligned;
	logic              out_of_range;
	logic [AW-1:0]     rel_word;
	logic [WS-1:0]     rel_bit;
	logic [WORD_W-1:0] rel_onehot;
	logic              rel_set;
	logic [PW-1:0]     word_used;
	logic              wr_en;
	logic [AW-1:0]     wr_addr;
	logic [WORD_W-1:0] wr_data;
	logic [AW-1:0]     rd_addr;

	// Valid page range
	assign lim    = (page_count_q < MAXP_CLIP) ? page_count_q : MAXP_CLIP;
	assign lim_m1 = lim - PW'(1);
	assign empty  = (first_page_q >= lim);
	assign span   = empty ? '0 : (lim - first_page_q);
	assign fw     = first_page_q[PW-1:WS];
	assign lw     = lim_m1[PW-1:WS];
	assign last   = (wrd_q == lw);

	// Mask off pages outside the range in the first and last words
	assign lo_mask = (wrd_q == fw) ? ({WORD_W{1'b1}} << first_page_q[WS-1:0])
	                               : {WORD_W{1'b1}};
	assign hi_mask = last ? ({WORD_W{1'b1}} >> (~lim_m1[WS-1:0]))
	                      : {WORD_W{1'b1}};
	assign mask    = lo_mask & hi_mask;

	// Find the lowest free page in the current word
	assign free_bits = ~rdata & mask;
	assign hit       = |free_bits;

	always_comb begin
		bit_idx = '0;
		for (int i = WORD_W - 1; i >= 0; i--) begin
			if (free_bits[i]) begin
				bit_idx = WS'(i);
			end
		end
	end

	assign grant_page = {wrd_q, bit_idx};
	assign al_onehot  = WORD_W'(1) << bit_idx;
	assign word_used  = PW'($countones(rdata & mask));

	// Release address checks
	assign rel_idx      = addr_q[ppa_pkg::ADDR_W-1:ppa_pkg::PAGE_SHIFT];
	assign misaligned   = |addr_q[ppa_pkg::PAGE_SHIFT-1:0];
	assign out_of_range = (rel_idx < ppa_pkg::IDX_W'(first_page_q)) ||
	                      (rel_idx >= ppa_pkg::IDX_W'(lim));
	assign rel_word     = AW'(rel_idx[PW-1:WS]);
	assign rel_bit      = rel_idx[WS-1:0];
	assign rel_onehot   = WORD_W'(1) << rel_bit;
	assign rel_set      = rdata[rel_bit];

	// Usage-map write port: clearing pass, allocate set, release clear
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = clr_q;
		wr_data = '0;
		if (cmd.clr_wr) begin
			wr_en = 1'b1;
		end else if (cmd.al_chk && hit) begin
			wr_en   = 1'b1;
			wr_addr = AW'(wrd_q);
			wr_data = rdata | al_onehot;
		end else if (cmd.rel_chk && rel_set) begin
			wr_en   = 1'b1;
			wr_addr = rel_word;
			wr_data = rdata & ~rel_onehot;
		end
	end

	assign rd_addr = cmd.rd_rel ? rel_word : AW'(wrd_q);

	ppa_ram #(
		.WIDTH (WORD_W),
		.DEPTH (DEPTH)
	) u_map (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (cmd.rd_en),
		.rd_addr (rd_addr),
		.rd_data (rdata)
	);

	// Control registers: configuration, usage count, sweep counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_page_q <= ppa_pkg::FIRST_PAGE_RST;
			page_count_q <= ppa_pkg::PAGE_COUNT_RST;
			dirty_q      <= 1'b0;
			used_q       <= '0;
			clr_q        <= '0;
			wrd_q        <= '0;
			rsp_valid_q  <= 1'b0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					ppa_pkg::REG_FIRST_PAGE: begin
						first_page_q <= cfg_data;
						dirty_q      <= 1'b1;
					end
					ppa_pkg::REG_PAGE_COUNT: begin
						page_count_q <= cfg_data;
						dirty_q      <= 1'b1;
					end
					default: begin
					end
				endcase
			end else if (cmd.rc_start) begin
				dirty_q <= 1'b0;
			end

			if (cmd.clr_wr) begin
				clr_q <= clr_q + AW'(1);
			end

			if (cmd.cnt_init) begin
				wrd_q <= fw;
			end else if (cmd.cnt_next) begin
				wrd_q <= wrd_q + IW'(1);
			end

			// Track used pages inside the range
			if (cmd.rc_start) begin
				used_q <= '0;
			end else if (cmd.rc_acc) begin
				used_q <= used_q + word_used;
			end else if (cmd.al_chk && hit) begin
				used_q <= used_q + PW'(1);
			end else if (cmd.rel_chk && rel_set) begin
				used_q <= used_q - PW'(1);
			end

			// Output register: load a result, drop it on transfer
			if (cmd.rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			op_q    <= req.operation;
			addr_q  <= req.page_address;
			gaddr_q <= '0;
			stat_q  <= ppa_pkg::ST_OOM;
		end else if (cmd.rel_reject) begin
			stat_q <= misaligned ? ppa_pkg::ST_MISALIGNED : ppa_pkg::ST_RANGE;
		end else if (cmd.oom) begin
			stat_q <= ppa_pkg::ST_OOM;
		end else if (cmd.al_chk && hit) begin
			stat_q  <= ppa_pkg::ST_OK;
			gaddr_q <= {grant_page[ppa_pkg::GADDR_W-ppa_pkg::PAGE_SHIFT-1:0],
			            {ppa_pkg::PAGE_SHIFT{1'b0}}};
		end else if (cmd.rel_chk) begin
			stat_q <= rel_set ? ppa_pkg::ST_OK : ppa_pkg::ST_NOT_USED;
		end

		if (cmd.rsp_load) begin
			rsp_q.granted_address <= gaddr_q;
			rsp_q.status          <= stat_q;
			rsp_q.free_count      <= span - used_q;
		end
	end

	assign rsp       = rsp_q;
	assign rsp_valid = rsp_valid_q;

	// Status toward the controller
	always_comb begin
		sts            = '0;
		sts.clr_last   = (clr_q == CLR_END);
		sts.dirty      = dirty_q;
		sts.empty      = empty;
		sts.is_release = (op_q == ppa_pkg::OP_RELEASE);
		sts.rel_bad    = misaligned || out_of_range;
		sts.hit        = hit;
		sts.last       = last;
		sts.rsp_free   = !rsp_valid_q || rsp_ready;
	end

endmodule

`default_nettype wire

>>> rtl/core/physical_page_allocator_top.sv
// Allocate scans usage-map words (32 pages per word, 16 if MAX_PAGES < 32) from
// the first word of the range until the first free page or the range end; an empty
// range gives OOM. A release that fails its address checks skips the map read. After
// a register write the next item first recounts the range word by word. One item in
// flight; the next request can be taken in the cycle after the result loads. Reset:
// async, active low; a clearing pass zeroes all usage-map words before req_ready.
`default_nettype none

module physical_page_allocator_top #(
	parameter int MAX_PAGES = ppa_pkg::MAX_PAGES
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          req_valid,
	output logic                               req_ready,
	input  wire ppa_pkg::req_t                 req,
	output logic                               rsp_valid,
	input  wire logic                          rsp_ready,
	output ppa_pkg::rsp_t                      rsp,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [ppa_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [ppa_pkg::PAGE_W-1:0]    cfg_data
);

	ppa_pkg::cmd_t cmd;
	ppa_pkg::sts_t sts;

	// Register writes are taken in any cycle
	assign cfg_ready = 1'b1;

	ppa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	ppa_datapath #(
		.MAX_PAGES (MAX_PAGES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.req       (req),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule

`default_nettype wire
